>>> hdl/bxema_pkg.sv
// ----------------------------------------------------------------------------
// bxema_pkg
// Shared widths, types and codes of the two-speed box smoother.
// ----------------------------------------------------------------------------
package bxema_pkg;

    localparam int SLOTS      = 16;
    localparam int FRAC_BITS  = 8;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_IDX_W = 4;
    localparam int SLOT_CMP_W = SLOT_IDX_W + 1;

    localparam int PIX_W      = 16;
    localparam int ST_W       = PIX_W + FRAC_BITS;
    localparam int DIFF_W     = ST_W + 1;
    localparam int GAIN_W     = 9;
    localparam int GAIN_SHIFT = 8;
    localparam int GAIN_ONE   = 1 << GAIN_SHIFT;
    localparam int PROD_W     = DIFF_W + GAIN_W + 1;
    localparam int STEP_W     = PROD_W - GAIN_SHIFT;
    localparam int DZ_W       = 15;
    localparam int LIMIT_W    = DZ_W + FRAC_BITS;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;
    localparam int COORDS     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEADZONE  = 2'd0,
        REG_GAIN_FAST = 2'd1,
        REG_GAIN_SLOW = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_SKIP   = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_LOAD   = 2'd2,
        MODE_UPDATE = 2'd3
    } slot_mode_t;

    typedef logic [COORDS-1:0][PIX_W-1:0]  pix_box_t;
    typedef logic [COORDS-1:0][ST_W-1:0]   st_box_t;
    typedef logic [COORDS-1:0][PROD_W-1:0] prod_box_t;

    function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
        return (g > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : g;
    endfunction

endpackage

>>> hdl/bxema_in_if.sv
// ----------------------------------------------------------------------------
// bxema_in_if
// Raw box channel: slot number and box coordinates in whole pixels.
// ----------------------------------------------------------------------------
interface bxema_in_if;

    logic                                valid;
    logic                                ready;
    logic [bxema_pkg::SLOT_IDX_W-1:0]    slot_index;
    logic signed [bxema_pkg::PIX_W-1:0]  raw_x;
    logic signed [bxema_pkg::PIX_W-1:0]  raw_y;
    logic signed [bxema_pkg::PIX_W-1:0]  raw_w;
    logic signed [bxema_pkg::PIX_W-1:0]  raw_h;

    modport source (output valid, slot_index, raw_x, raw_y, raw_w, raw_h, input ready);
    modport sink   (input valid, slot_index, raw_x, raw_y, raw_w, raw_h, output ready);

endinterface

>>> hdl/bxema_out_if.sv
// ----------------------------------------------------------------------------
// bxema_out_if
// Smoothed box channel: coordinates truncated toward zero.
// ----------------------------------------------------------------------------
interface bxema_out_if;

    logic                                valid;
    logic                                ready;
    logic signed [bxema_pkg::PIX_W-1:0]  smooth_x;
    logic signed [bxema_pkg::PIX_W-1:0]  smooth_y;
    logic signed [bxema_pkg::PIX_W-1:0]  smooth_w;
    logic signed [bxema_pkg::PIX_W-1:0]  smooth_h;

    modport source (output valid, smooth_x, smooth_y, smooth_w, smooth_h, input ready);
    modport sink   (input valid, smooth_x, smooth_y, smooth_w, smooth_h, output ready);

endinterface

>>> hdl/bxema_cfg_if.sv
// ----------------------------------------------------------------------------
// bxema_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface bxema_cfg_if;

    logic                                valid;
    logic                                ready;
    logic [bxema_pkg::CFG_IDX_W-1:0]     index;
    logic [bxema_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);

endinterface

>>> hdl/box_two_speed_ema_smoother_core.sv
// ----------------------------------------------------------------------------
// box_two_speed_ema_smoother_core
// An accepted item passes through stage 1, stage 2 and the output register.
// Throughput: one item per cycle unless the output stalls; an item for a slot
// still in the read-modify-write path of the box memory waits until it leaves.
// Reset clears all slot valid flags and sets the registers to their defaults;
// the box memory is not cleared; its contents are used only for valid slots.
// ----------------------------------------------------------------------------
module box_two_speed_ema_smoother_core (
    input  logic          clk,
    input  logic          rst_n,
    bxema_in_if.sink      box,
    bxema_out_if.source   smooth,
    bxema_cfg_if.sink     cfg
);

    logic [bxema_pkg::DZ_W-1:0]         deadzone_reg;
    logic [bxema_pkg::GAIN_W-1:0]       gain_fast_reg;
    logic [bxema_pkg::GAIN_W-1:0]       gain_slow_reg;

    logic [bxema_pkg::SLOTS-1:0]        slot_valid_reg;
    bxema_pkg::st_box_t                 mem [bxema_pkg::SLOTS];
    bxema_pkg::st_box_t                 rd_data_reg;

    logic                               s1_valid_reg;
    logic [bxema_pkg::SLOT_IDX_W-1:0]   s1_slot_reg;
    bxema_pkg::pix_box_t                s1_raw_reg;
    logic                               s1_zero_reg;
    logic                               s1_oob_reg;

    logic                               s2_valid_reg;
    logic [bxema_pkg::SLOT_IDX_W-1:0]   s2_slot_reg;
    bxema_pkg::slot_mode_t              s2_mode_reg;
    bxema_pkg::pix_box_t                s2_raw_reg;
    bxema_pkg::st_box_t                 s2_s_reg;
    bxema_pkg::prod_box_t               s2_prod_reg;

    logic                               out_valid_reg;
    bxema_pkg::pix_box_t                out_box_reg;

    logic                               advance;
    logic                               hazard;
    logic                               accept;
    bxema_pkg::pix_box_t                in_raw;
    bxema_pkg::slot_mode_t              s1_mode;
    bxema_pkg::prod_box_t               s1_prod;
    bxema_pkg::st_box_t                 s2_box;
    bxema_pkg::pix_box_t                s2_pix;
    logic                               wr_en;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg  <= bxema_pkg::DZ_W'(4);
            gain_fast_reg <= bxema_pkg::GAIN_W'(128);
            gain_slow_reg <= bxema_pkg::GAIN_W'(32);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                bxema_pkg::REG_DEADZONE:  deadzone_reg  <= cfg.data[bxema_pkg::DZ_W-1:0];
                bxema_pkg::REG_GAIN_FAST: gain_fast_reg <= cfg.data[bxema_pkg::GAIN_W-1:0];
                bxema_pkg::REG_GAIN_SLOW: gain_slow_reg <= cfg.data[bxema_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and interlock
    assign advance = !out_valid_reg || smooth.ready;
    assign hazard  = (s1_valid_reg && (s1_slot_reg == box.slot_index))
                  || (s2_valid_reg && (s2_slot_reg == box.slot_index));
    assign box.ready = advance && !hazard;
    assign accept    = box.valid && box.ready;
    assign in_raw    = {box.raw_h, box.raw_w, box.raw_y, box.raw_x};

    // Box memory
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= mem[box.slot_index[bxema_pkg::SLOT_W-1:0]];
        end
        if (wr_en)
        begin
            mem[s2_slot_reg[bxema_pkg::SLOT_W-1:0]] <= s2_box;
        end
    end

    // Stage 1: difference, gain pick, product
    always_comb
    begin
        logic signed [bxema_pkg::DIFF_W-1:0]  d;
        logic [bxema_pkg::DIFF_W-1:0]         mag;
        logic [bxema_pkg::GAIN_W-1:0]         g;
        logic signed [bxema_pkg::ST_W-1:0]    target;
        logic [bxema_pkg::DIFF_W-1:0]         limit;

        limit = bxema_pkg::DIFF_W'({deadzone_reg, bxema_pkg::FRAC_BITS'(0)});
        for (int k = 0; k < bxema_pkg::COORDS; k++)
        begin
            target = $signed({s1_raw_reg[k], bxema_pkg::FRAC_BITS'(0)});
            d      = bxema_pkg::DIFF_W'(target) - bxema_pkg::DIFF_W'($signed(rd_data_reg[k]));
            mag    = d[bxema_pkg::DIFF_W-1] ? -d : d;
            g      = (mag > limit) ? bxema_pkg::clamp_gain(gain_fast_reg)
                                   : bxema_pkg::clamp_gain(gain_slow_reg);
            s1_prod[k] = bxema_pkg::PROD_W'($signed({1'b0, g})) * bxema_pkg::PROD_W'(d);
        end

        if (s1_oob_reg)
        begin
            s1_mode = bxema_pkg::MODE_SKIP;
        end
        else if (s1_zero_reg)
        begin
            s1_mode = bxema_pkg::MODE_CLEAR;
        end
        else if (!slot_valid_reg[s1_slot_reg[bxema_pkg::SLOT_W-1:0]])
        begin
            s1_mode = bxema_pkg::MODE_LOAD;
        end
        else
        begin
            s1_mode = bxema_pkg::MODE_UPDATE;
        end
    end

    // Stage 2: round, step, write back, truncate
    always_comb
    begin
        logic signed [bxema_pkg::PROD_W-1:0] rnd;
        logic signed [bxema_pkg::STEP_W-1:0] step;
        logic signed [bxema_pkg::ST_W-1:0]   s_new;

        for (int k = 0; k < bxema_pkg::COORDS; k++)
        begin
            rnd  = $signed(s2_prod_reg[k]) + bxema_pkg::PROD_W'(bxema_pkg::GAIN_ONE / 2);
            step = bxema_pkg::STEP_W'(rnd >>> bxema_pkg::GAIN_SHIFT);
            if (s2_mode_reg == bxema_pkg::MODE_LOAD)
            begin
                s_new = $signed({s2_raw_reg[k], bxema_pkg::FRAC_BITS'(0)});
            end
            else
            begin
                s_new = $signed(s2_s_reg[k]) + step[bxema_pkg::ST_W-1:0];
            end
            s2_box[k] = s_new;
            s2_pix[k] = s_new[bxema_pkg::ST_W-1:bxema_pkg::FRAC_BITS]
                      + bxema_pkg::PIX_W'(s_new[bxema_pkg::ST_W-1]
                                          && (s_new[bxema_pkg::FRAC_BITS-1:0] != '0));
        end
    end

    assign wr_en = s2_valid_reg && advance
                && ((s2_mode_reg == bxema_pkg::MODE_LOAD)
                    || (s2_mode_reg == bxema_pkg::MODE_UPDATE));

    // Pipeline control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
            if (s2_valid_reg)
            begin
                case (s2_mode_reg)
                    bxema_pkg::MODE_CLEAR:
                        slot_valid_reg[s2_slot_reg[bxema_pkg::SLOT_W-1:0]] <= 1'b0;
                    bxema_pkg::MODE_LOAD:
                        slot_valid_reg[s2_slot_reg[bxema_pkg::SLOT_W-1:0]] <= 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // Pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_slot_reg <= box.slot_index;
            s1_raw_reg  <= in_raw;
            s1_zero_reg <= (in_raw == '0);
            s1_oob_reg  <= ({1'b0, box.slot_index}
                            >= bxema_pkg::SLOT_CMP_W'(bxema_pkg::SLOTS));
        end
        if (advance)
        begin
            s2_slot_reg <= s1_slot_reg;
            s2_mode_reg <= s1_mode;
            s2_raw_reg  <= s1_raw_reg;
            s2_s_reg    <= rd_data_reg;
            s2_prod_reg <= s1_prod;
            if ((s2_mode_reg == bxema_pkg::MODE_LOAD)
                || (s2_mode_reg == bxema_pkg::MODE_UPDATE))
            begin
                out_box_reg <= s2_pix;
            end
            else
            begin
                out_box_reg <= '0;
            end
        end
    end

    assign smooth.valid    = out_valid_reg;
    assign smooth.smooth_x = out_box_reg[0];
    assign smooth.smooth_y = out_box_reg[1];
    assign smooth.smooth_w = out_box_reg[2];
    assign smooth.smooth_h = out_box_reg[3];

    // Checks
    a_no_same_slot_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s1_valid_reg |-> box.slot_index != s1_slot_reg)
        else $error("item accepted for slot in stage 1");

    a_no_same_slot_s2: assert property (@(posedge clk) disable iff (!rst_n)
        accept && s2_valid_reg |-> box.slot_index != s2_slot_reg)
        else $error("item accepted for slot in stage 2");

    a_clear_drops_valid: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && advance && (s2_mode_reg == bxema_pkg::MODE_CLEAR)
        |=> !slot_valid_reg[$past(s2_slot_reg[bxema_pkg::SLOT_W-1:0])])
        else $error("slot still valid after clear");

    a_result_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && advance |=> out_valid_reg)
        else $error("result lost between stage 2 and output");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-speed box smoother. A short table of boxes
// and register writes covers loads, clears, saturated and zero gains and
// the coordinate extremes. Randomized phases follow, with tracking boxes,
// clears and noise under varied settings and idle patterns. Every result is
// compared against a table entry or an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 175;
    localparam int REPORT_MAX    = 10;
    localparam int ROW_BOX       = 0;
    localparam int ROW_CFG       = 1;

    typedef struct {
        int kind;
        int reg_idx;
        int data;
        int slot;
        int x;
        int y;
        int w;
        int h;
        int chk;
        int ex;
        int ey;
        int ew;
        int eh;
    } script_row_t;

    script_row_t directed_rows [25] = '{
        '{ROW_BOX, 0, 0, 0, 100, -200, 30, 40, 1, 100, -200, 30, 40},
        '{ROW_BOX, 0, 0, 0, 102, -200, 30, 40, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 0, 300, -190, 31, -40, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 0, -1, -1, -1, -1, 1, -1, -1, -1, -1},
        '{ROW_BOX, 0, 0, 15, 32767, -32768, 32767, -32768, 1, 32767, -32768, 32767, -32768},
        '{ROW_BOX, 0, 0, 15, -32768, 32767, -32768, 32767, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 15, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 7, 0, 0, 0, 0, 1, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 1, 0, 0, 0, 1, 1, 0, 0, 0, 1},
        '{ROW_BOX, 0, 0, 1, 0, 0, 0, -1, 0, 0, 0, 0, 0},
        '{ROW_CFG, bxema_pkg::REG_DEADZONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bxema_pkg::REG_GAIN_FAST, 511, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bxema_pkg::REG_GAIN_SLOW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 2, 10, 20, 30, 40, 1, 10, 20, 30, 40},
        '{ROW_BOX, 0, 0, 2, 11, 20, -30, 40, 1, 11, 20, -30, 40},
        '{ROW_CFG, bxema_pkg::REG_DEADZONE, 32767, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bxema_pkg::REG_GAIN_SLOW, 300, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 2, -5, 7, 8, 9, 1, -5, 7, 8, 9},
        '{ROW_CFG, bxema_pkg::REG_GAIN_FAST, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bxema_pkg::REG_GAIN_SLOW, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_CFG, bxema_pkg::REG_DEADZONE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ROW_BOX, 0, 0, 2, 1000, -1000, 5, 5, 1, -5, 7, 8, 9},
        '{ROW_BOX, 0, 0, 3, -32768, -32768, -32768, -32768, 1, -32768, -32768, -32768, -32768},
        '{ROW_BOX, 0, 0, 3, 32767, 32767, 32767, 32767, 1, -32768, -32768, -32768, -32768}
    };

    string coord_names [bxema_pkg::COORDS] = '{"smooth_x", "smooth_y", "smooth_w", "smooth_h"};

    logic clk;
    logic rst_n;

    bxema_in_if  box_if();
    bxema_out_if smooth_if();
    bxema_cfg_if cfg_if();

    box_two_speed_ema_smoother_core u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .box    (box_if),
        .smooth (smooth_if),
        .cfg    (cfg_if)
    );

    logic [bxema_pkg::DZ_W-1:0]   deadzone_q;
    logic [bxema_pkg::GAIN_W-1:0] fast_q;
    logic [bxema_pkg::GAIN_W-1:0] slow_q;
    bit                           slot_live [bxema_pkg::SLOTS];
    longint                       slot_acc [bxema_pkg::SLOTS][bxema_pkg::COORDS];
    bxema_pkg::pix_box_t          pending_boxes [$];

    int src_idle_pct;
    int snk_stall_pct;
    int mismatch_cnt;
    int result_cnt;
    int box_cnt;
    int load_cnt;
    int update_cnt;
    int clear_cnt;
    int cfg_cnt;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("[box_two_speed_ema_smoother_core] ERROR");
        $finish;
    end

    function automatic bxema_pkg::pix_box_t smooth_predict(
        input logic [bxema_pkg::SLOT_IDX_W-1:0] slot,
        input bxema_pkg::pix_box_t raw);
        bxema_pkg::pix_box_t result;
        longint   one;
        longint   d;
        longint   mag;
        longint   gain;
        int       s;
        result = '0;
        one    = longint'(1) << bxema_pkg::FRAC_BITS;
        s      = int'(slot);
        if (s >= bxema_pkg::SLOTS)
            return result;
        if (raw == '0)
        begin
            slot_live[s] = 1'b0;
            clear_cnt++;
            return result;
        end
        for (int k = 0; k < bxema_pkg::COORDS; k++)
        begin
            if (!slot_live[s])
            begin
                slot_acc[s][k] = longint'($signed(raw[k])) * one;
            end
            else
            begin
                d   = longint'($signed(raw[k])) * one - slot_acc[s][k];
                mag = (d < 0) ? -d : d;
                if (mag > longint'(deadzone_q) * one)
                    gain = (fast_q > bxema_pkg::GAIN_ONE) ? bxema_pkg::GAIN_ONE
                                                          : longint'(fast_q);
                else
                    gain = (slow_q > bxema_pkg::GAIN_ONE) ? bxema_pkg::GAIN_ONE
                                                          : longint'(slow_q);
                slot_acc[s][k] = slot_acc[s][k]
                               + ((gain * d + bxema_pkg::GAIN_ONE / 2)
                                  >>> bxema_pkg::GAIN_SHIFT);
            end
            result[k] = bxema_pkg::PIX_W'(slot_acc[s][k] / one);
        end
        if (slot_live[s])
            update_cnt++;
        else
            load_cnt++;
        slot_live[s] = 1'b1;
        return result;
    endfunction

    function automatic logic [bxema_pkg::PIX_W-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h0001;
            default: return bxema_pkg::PIX_W'($urandom);
        endcase
    endfunction

    function automatic bxema_pkg::pix_box_t pick_box(input int s);
        bxema_pkg::pix_box_t b;
        int       r;
        int       target;
        int       spread;
        int       mode;
        b = '0;
        r = $urandom_range(0, 99);
        if (r < 5)
            return b;
        spread = (deadzone_q < 60) ? int'(deadzone_q) + 2 : 64;
        for (int k = 0; k < bxema_pkg::COORDS; k++)
        begin
            if (r < 12)
            begin
                b[k] = pick_extreme();
            end
            else if (!slot_live[s])
            begin
                b[k] = $urandom_range(0, 1) ? bxema_pkg::PIX_W'($urandom)
                                            : bxema_pkg::PIX_W'($urandom_range(0, 1920));
            end
            else
            begin
                mode   = $urandom_range(0, 9);
                target = int'(slot_acc[s][k] / 256);
                if (mode < 5)
                    target = target + int'($urandom_range(0, 2 * spread)) - spread;
                else if (mode < 8)
                    target = target + int'($urandom_range(0, 1200)) - 600;
                else
                    target = int'($urandom_range(0, 65535)) - 32768;
                if (target > 32767)
                    target = 32767;
                if (target < -32768)
                    target = -32768;
                b[k] = bxema_pkg::PIX_W'(target);
            end
        end
        return b;
    endfunction

    task automatic send_box(input logic [bxema_pkg::SLOT_IDX_W-1:0] slot,
                            input bxema_pkg::pix_box_t raw,
                            input bit typed, input bxema_pkg::pix_box_t typed_box);
        bxema_pkg::pix_box_t want;
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            box_if.valid <= 1'b0;
            @(negedge clk);
        end
        box_if.valid      <= 1'b1;
        box_if.slot_index <= slot;
        box_if.raw_x      <= raw[0];
        box_if.raw_y      <= raw[1];
        box_if.raw_w      <= raw[2];
        box_if.raw_h      <= raw[3];
        @(posedge clk);
        while (!box_if.ready)
            @(posedge clk);
        want = smooth_predict(slot, raw);
        pending_boxes.push_back(typed ? typed_box : want);
        box_cnt++;
        @(negedge clk);
    endtask

    task automatic settle_block();
        box_if.valid <= 1'b0;
        while (pending_boxes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input bxema_pkg::cfg_reg_t idx, input int value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= bxema_pkg::CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        case (idx)
            bxema_pkg::REG_DEADZONE:  deadzone_q = value[bxema_pkg::DZ_W-1:0];
            bxema_pkg::REG_GAIN_FAST: fast_q     = value[bxema_pkg::GAIN_W-1:0];
            bxema_pkg::REG_GAIN_SLOW: slow_q     = value[bxema_pkg::GAIN_W-1:0];
            default: ;
        endcase
        cfg_cnt++;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
        @(negedge clk);
    endtask

    function automatic int pick_gain();
        return ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 256))
                                           : int'($urandom_range(0, 32767));
    endfunction

    initial
    begin
        smooth_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            smooth_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        bxema_pkg::pix_box_t want;
        bxema_pkg::pix_box_t got;
        if (rst_n && smooth_if.valid && smooth_if.ready)
        begin
            result_cnt++;
            got = {smooth_if.smooth_h, smooth_if.smooth_w, smooth_if.smooth_y,
                   smooth_if.smooth_x};
            if (pending_boxes.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("result %0d arrived with no box pending", result_cnt);
            end
            else
            begin
                want = pending_boxes.pop_front();
                for (int k = 0; k < bxema_pkg::COORDS; k++)
                begin
                    if (got[k] !== want[k])
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX)
                            $display("result %0d %s: expected %0d, got %0d", result_cnt,
                                     coord_names[k], $signed(want[k]), $signed(got[k]));
                    end
                end
            end
        end
    end

    initial
    begin
        script_row_t                        row;
        bxema_pkg::pix_box_t                raw;
        bxema_pkg::pix_box_t                typed_box;
        logic [bxema_pkg::SLOT_IDX_W-1:0]   slot;

        rst_n             = 1'b0;
        box_if.valid      = 1'b0;
        box_if.slot_index = '0;
        box_if.raw_x      = '0;
        box_if.raw_y      = '0;
        box_if.raw_w      = '0;
        box_if.raw_h      = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = bxema_pkg::REG_DEADZONE;
        cfg_if.data       = '0;
        deadzone_q        = bxema_pkg::DZ_W'(4);
        fast_q            = bxema_pkg::GAIN_W'(128);
        slow_q            = bxema_pkg::GAIN_W'(32);
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        mismatch_cnt      = 0;
        result_cnt        = 0;
        box_cnt           = 0;
        load_cnt          = 0;
        update_cnt        = 0;
        clear_cnt         = 0;
        cfg_cnt           = 0;
        for (int s = 0; s < bxema_pkg::SLOTS; s++)
            slot_live[s] = 1'b0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(directed_rows); i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                settle_block();
                write_reg(bxema_pkg::cfg_reg_t'(row.reg_idx), row.data);
            end
            else
            begin
                raw       = {bxema_pkg::PIX_W'(row.h), bxema_pkg::PIX_W'(row.w),
                             bxema_pkg::PIX_W'(row.y), bxema_pkg::PIX_W'(row.x)};
                typed_box = {bxema_pkg::PIX_W'(row.eh), bxema_pkg::PIX_W'(row.ew),
                             bxema_pkg::PIX_W'(row.ey), bxema_pkg::PIX_W'(row.ex)};
                send_box(bxema_pkg::SLOT_IDX_W'(row.slot), raw, row.chk != 0, typed_box);
            end
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            settle_block();
            case (phase)
                0:
                begin
                    write_reg(bxema_pkg::REG_DEADZONE, 4);
                    write_reg(bxema_pkg::REG_GAIN_FAST, 128);
                    write_reg(bxema_pkg::REG_GAIN_SLOW, 32);
                end
                1:
                begin
                    write_reg(bxema_pkg::REG_DEADZONE, 0);
                    write_reg(bxema_pkg::REG_GAIN_FAST, 256);
                    write_reg(bxema_pkg::REG_GAIN_SLOW, 0);
                end
                2:
                begin
                    write_reg(bxema_pkg::REG_DEADZONE, 32767);
                    write_reg(bxema_pkg::REG_GAIN_FAST, 0);
                    write_reg(bxema_pkg::REG_GAIN_SLOW, 256);
                end
                3:
                begin
                    write_reg(bxema_pkg::REG_DEADZONE, 1);
                    write_reg(bxema_pkg::REG_GAIN_FAST, 511);
                    write_reg(bxema_pkg::REG_GAIN_SLOW, 300);
                end
                default:
                begin
                    write_reg(bxema_pkg::REG_DEADZONE,
                              $urandom_range(0, 1) ? int'($urandom_range(0, 20))
                                                   : int'($urandom_range(0, 32767)));
                    write_reg(bxema_pkg::REG_GAIN_FAST, pick_gain());
                    write_reg(bxema_pkg::REG_GAIN_SLOW, pick_gain());
                end
            endcase
            case (phase % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 68; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 68; end
                default: begin src_idle_pct = 14; snk_stall_pct = 14; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 5 && n == PHASE_ITEMS / 2)
                    settle_block();
                slot = bxema_pkg::SLOT_IDX_W'($urandom_range(0, bxema_pkg::SLOTS - 1));
                send_box(slot, pick_box(int'(slot)), 1'b0, '0);
            end
        end

        src_idle_pct  = 0;
        snk_stall_pct = 0;
        settle_block();

        $display("Sent %0d boxes (%0d loads, %0d updates, %0d clears) with %0d register writes",
                 box_cnt, load_cnt, update_cnt, clear_cnt, cfg_cnt);
        $display("across %0d randomized phases; %0d results checked, %0d field mismatches.",
                 PHASES, result_cnt, mismatch_cnt);
        if (mismatch_cnt == 0 && pending_boxes.size() == 0)
            $display("[box_two_speed_ema_smoother_core] OK");
        else
            $display("[box_two_speed_ema_smoother_core] ERROR");
        $finish;
    end

endmodule

>>> sim.f
hdl/bxema_pkg.sv
hdl/bxema_in_if.sv
hdl/bxema_out_if.sv
hdl/bxema_cfg_if.sv
hdl/box_two_speed_ema_smoother_core.sv
verif/testbench.sv
